[hdl/bresenham_line_point_generator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the line point generator checker
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_POINT_GENERATOR_MACROS_SVH
`define BRESENHAM_LINE_POINT_GENERATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BLPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blpg assertion failed");

// antecedent implies consequent in the next cycle
`define BLPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blpg assertion failed");

`endif

[hdl/blpg_pkg.sv]
// ----------------------------------------------------------------------------
// blpg_pkg
// Shared types and constants for the line point generator.
// ----------------------------------------------------------------------------
package blpg_pkg;

    localparam int COORD_W     = 6;
    localparam int ERR_W       = COORD_W + 2;
    localparam int GRID_SIZE_D = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t            x;
        coord_t            y;
        coord_t            xe;
        coord_t            ye;
        coord_t            dx;
        coord_t            dy;
        logic              sx;
        logic              sy;
        logic [ERR_W-1:0]  err;
    } line_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[hdl/bresenham_line_point_generator.sv]
// ----------------------------------------------------------------------------
// bresenham_line_point_generator
// Traces a grid line from start to end, one point per result.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   in       | in_valid / in_stall  | x_start y_start x_end y_end
//   out      | out_valid / out_stall| point_x point_y last_point
//
// A request yields max(dx,dy)+1 points; the tracer loads it from the queue
// and then steps through them, pausing while out_stall holds the output.
// Two requests can wait in the queue while a line is traced.
// Reset clears the queue, the tracer and the output valid.
// out_stall, while out_valid is high, holds the output register and pauses the tracer.
// ----------------------------------------------------------------------------
module bresenham_line_point_generator
    import blpg_pkg::*;
#(
    parameter int GRID_SIZE   = GRID_SIZE_D,
    parameter int QUEUE_DEPTH = blpg_pkg::QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,
    output logic   out_valid,
    input  logic   out_stall,
    output coord_t point_x,
    output coord_t point_y,
    output logic   last_point
);

    line_desc_t    front_desc;
    line_desc_t    q_data;
    queue_status_t q_status;
    logic          q_pop;

    assign in_stall = q_status.full;

    blpg_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .desc    (front_desc)
    );

    blpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_desc),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    blpg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

endmodule

[hdl/blpg_front.sv]
// ----------------------------------------------------------------------------
// blpg_front
// Clamps the endpoints and derives deltas, directions and the initial error.
// ----------------------------------------------------------------------------
module blpg_front
    import blpg_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_D
)
(
    input  coord_t     x_start,
    input  coord_t     y_start,
    input  coord_t     x_end,
    input  coord_t     y_end,
    output line_desc_t desc
);

    localparam coord_t MAX_C = COORD_W'(GRID_SIZE - 1);

    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;

    always_comb
    begin
        xs = (x_start > MAX_C) ? MAX_C : x_start;
        ys = (y_start > MAX_C) ? MAX_C : y_start;
        xe = (x_end   > MAX_C) ? MAX_C : x_end;
        ye = (y_end   > MAX_C) ? MAX_C : y_end;

        desc.x   = xs;
        desc.y   = ys;
        desc.xe  = xe;
        desc.ye  = ye;
        desc.dx  = (xe > xs) ? (xe - xs) : (xs - xe);
        desc.dy  = (ye > ys) ? (ye - ys) : (ys - ye);
        desc.sx  = (xs < xe);
        desc.sy  = (ys < ye);
        desc.err = {2'b00, desc.dx} - {2'b00, desc.dy};
    end

endmodule

[hdl/blpg_queue.sv]
// ----------------------------------------------------------------------------
// blpg_queue
// Short descriptor queue between the front and the tracer.
// ----------------------------------------------------------------------------
module blpg_queue
    import blpg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  line_desc_t    push_data,
    input  logic          pop,
    output line_desc_t    pop_data,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    line_desc_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/blpg_back.sv]
// ----------------------------------------------------------------------------
// blpg_back
// Line tracer: steps the error term and emits one point per cycle while tracing, unless out_stall holds the output.
// ----------------------------------------------------------------------------
module blpg_back
    import blpg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  line_desc_t    q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output coord_t        point_x,
    output coord_t        point_y,
    output logic          last_point
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    line_desc_t        cur_reg;
    line_desc_t        cur_next;
    logic              ovalid_reg;
    logic              ovalid_next;
    coord_t            px_reg;
    coord_t            py_reg;
    logic              plast_reg;
    logic              emit;
    logic              at_end;
    logic              step_x;
    logic              step_y;
    logic signed [ERR_W:0] e2;
    logic signed [ERR_W:0] ndy;
    logic signed [ERR_W:0] pdx;
    logic signed [ERR_W:0] err_sum;

    assign out_valid  = ovalid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign last_point = plast_reg;

    assign at_end = (cur_reg.x == cur_reg.xe) && (cur_reg.y == cur_reg.ye);
    assign emit   = (state_reg == ST_RUN) && (!ovalid_reg || !out_stall);
    assign q_pop  = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        e2      = $signed({cur_reg.err, 1'b0});
        pdx     = $signed({3'b000, cur_reg.dx});
        ndy     = -$signed({3'b000, cur_reg.dy});
        step_x  = (e2 > ndy);
        step_y  = (e2 < pdx);
        err_sum = $signed({cur_reg.err[ERR_W-1], cur_reg.err})
                  + (step_x ? ndy : '0) + (step_y ? pdx : '0);
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        ovalid_next = ovalid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    cur_next   = q_data;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    ovalid_next  = 1'b1;
                    cur_next.err = err_sum[ERR_W-1:0];
                    if (step_x)
                    begin
                        cur_next.x = cur_reg.sx ? cur_reg.x + 1'b1 : cur_reg.x - 1'b1;
                    end
                    if (step_y)
                    begin
                        cur_next.y = cur_reg.sy ? cur_reg.y + 1'b1 : cur_reg.y - 1'b1;
                    end
                    if (at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            px_reg    <= cur_reg.x;
            py_reg    <= cur_reg.y;
            plast_reg <= at_end;
        end
    end

endmodule

[hdl/blpg_checker.sv]
// ----------------------------------------------------------------------------
// blpg_checker
// Port-level checks on the output stream of the line point generator.
// ----------------------------------------------------------------------------
`include "bresenham_line_point_generator_macros.svh"

module blpg_checker
    import blpg_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   out_valid,
    input logic   out_stall,
    input coord_t point_x,
    input coord_t point_y,
    input logic   last_point
);

    coord_t prev_x_reg;
    coord_t prev_y_reg;
    logic   prev_last_reg;
    logic   take_mid;
    logic   held;
    logic   moved;
    logic   near_x;
    logic   near_y;

    always_ff @(posedge clk)
    begin
        prev_x_reg    <= point_x;
        prev_y_reg    <= point_y;
        prev_last_reg <= last_point;
    end

    assign take_mid = out_valid && !out_stall && !last_point;
    assign held     = (point_x == prev_x_reg) && (point_y == prev_y_reg)
                      && (last_point == prev_last_reg);
    assign moved    = (point_x != prev_x_reg) || (point_y != prev_y_reg);
    assign near_x   = (point_x == prev_x_reg) || (point_x == prev_x_reg + 6'd1)
                      || (point_x == prev_x_reg - 6'd1);
    assign near_y   = (point_y == prev_y_reg) || (point_y == prev_y_reg + 6'd1)
                      || (point_y == prev_y_reg - 6'd1);

    `BLPG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && held)

    // mid-line points follow back to back, each one cell away at most
    `BLPG_ASSERT_NEXT(a_step_near, take_mid, out_valid && near_x && near_y)

    `BLPG_ASSERT_NEXT(a_step_moves, take_mid, moved)

endmodule

bind bresenham_line_point_generator blpg_checker u_blpg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
);
